// ===== design/mop_pkg.sv =====
`default_nettype none
package mop_pkg;

  localparam int unsigned TimerBits     = 16;
  localparam int unsigned DebounceTicks = 50;

  localparam logic [TimerBits-1:0] TimerMax = {TimerBits{1'b1}};

  localparam logic [2:0] ModeStopped = 3'd0;
  localparam logic [2:0] ModeRunning = 3'd1;
  localparam logic [2:0] ModeLowCur  = 3'd2;
  localparam logic [2:0] ModeTrip    = 3'd3;
  localparam logic [2:0] ModeEstop   = 3'd4;

  localparam logic [2:0] RegZeroCode   = 3'd0;
  localparam logic [2:0] RegNoiseFloor = 3'd1;
  localparam logic [2:0] RegHighThr    = 3'd2;
  localparam logic [2:0] RegLowThr     = 3'd3;
  localparam logic [2:0] RegEmaAlpha   = 3'd4;
  localparam logic [2:0] RegConfirm    = 3'd5;
  localparam logic [2:0] RegGrace      = 3'd6;
  localparam logic [2:0] RegRestart    = 3'd7;

  typedef logic [TimerBits-1:0] timer_t;

  typedef struct packed {
    logic [15:0] high_threshold;
    logic [15:0] low_threshold;
    timer_t      confirm_ticks;
    timer_t      grace_ticks;
    timer_t      restart_ticks;
  } ctrl_cfg_t;

  typedef struct packed {
    logic       relay_en;
    logic [2:0] mode;
  } ctrl_out_t;

  function automatic timer_t sat_inc(input timer_t v);
    sat_inc = (v == TimerMax) ? v : v + timer_t'(1);
  endfunction

endpackage
`default_nettype wire

// ===== design/mop_meas.sv =====
`default_nettype none
module mop_meas (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [11:0] adc_code,
  input  wire logic [15:0] zero_code,
  input  wire logic [15:0] noise_floor,
  input  wire logic [8:0]  ema_alpha,
  output logic      [15:0] smoothed_nxt
);

  logic [15:0] smoothed_r;
  logic        valid_r;
  logic [15:0] scaled;
  logic [15:0] cur;
  logic [8:0]  alpha;
  logic signed [16:0] delta;
  logic signed [26:0] prod;
  logic signed [26:0] acc;

  always_comb begin
    scaled = {adc_code, 4'b0000};
    cur    = (scaled >= zero_code) ? scaled - zero_code : zero_code - scaled;
    if (cur < noise_floor) begin
      cur = 16'd0;
    end
    alpha = (ema_alpha > 9'd256) ? 9'd256 : ema_alpha;
    // a*cur + (256-a)*old == old*256 + a*(cur-old)
    delta = $signed({1'b0, cur}) - $signed({1'b0, smoothed_r});
    prod  = 27'($signed({1'b0, alpha}) * delta);
    acc   = $signed({3'b000, smoothed_r, 8'h00}) + prod + 27'sd128;
    smoothed_nxt = valid_r ? acc[23:8] : cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r <= '0;
      valid_r    <= 1'b0;
    end else if (step) begin
      smoothed_r <= smoothed_nxt;
      valid_r    <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== design/mop_ctrl.sv =====
`default_nettype none
module mop_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              button_level,
  input  wire logic [15:0]       smoothed,
  input  wire mop_pkg::ctrl_cfg_t cfg,
  output mop_pkg::ctrl_out_t     res
);

  logic [2:0]       mode_r, mode_nxt;
  logic             prev_raw_r, prev_raw_nxt;
  logic             stable_r, stable_nxt;
  logic             motor_r, motor_nxt;
  logic             oc_act_r, oc_act_nxt;
  logic             rs_pend_r, rs_pend_nxt;
  mop_pkg::timer_t  deb_r, deb_nxt;
  mop_pkg::timer_t  run_r, run_nxt;
  mop_pkg::timer_t  oc_r, oc_nxt;
  mop_pkg::timer_t  rs_r, rs_nxt;
  logic             grace;

  always_comb begin
    deb_nxt      = mop_pkg::sat_inc(deb_r);
    run_nxt      = mop_pkg::sat_inc(run_r);
    oc_nxt       = mop_pkg::sat_inc(oc_r);
    rs_nxt       = mop_pkg::sat_inc(rs_r);
    mode_nxt     = mode_r;
    stable_nxt   = stable_r;
    motor_nxt    = motor_r;
    oc_act_nxt   = oc_act_r;
    rs_pend_nxt  = rs_pend_r;
    prev_raw_nxt = button_level;

    // debounce
    if (button_level != prev_raw_r) begin
      deb_nxt = '0;
    end
    if ((32'(deb_nxt) > mop_pkg::DebounceTicks) && (button_level != stable_r)) begin
      stable_nxt = button_level;
      if (!button_level) begin
        if (mode_r == mop_pkg::ModeRunning || mode_r == mop_pkg::ModeLowCur) begin
          motor_nxt   = 1'b0;
          mode_nxt    = mop_pkg::ModeEstop;
          rs_pend_nxt = 1'b0;
        end else if (mode_r == mop_pkg::ModeStopped || mode_r == mop_pkg::ModeEstop) begin
          motor_nxt = 1'b1;
          run_nxt   = '0;
          mode_nxt  = mop_pkg::ModeRunning;
        end
      end
    end

    // protection
    grace = motor_nxt && (run_nxt < cfg.grace_ticks);
    if (!grace && motor_nxt && (smoothed > cfg.high_threshold)) begin
      if (!oc_act_r) begin
        oc_act_nxt = 1'b1;
        oc_nxt     = '0;
      end else if (oc_nxt >= cfg.confirm_ticks) begin
        motor_nxt   = 1'b0;
        mode_nxt    = mop_pkg::ModeTrip;
        rs_pend_nxt = 1'b0;
        oc_act_nxt  = 1'b0;
      end
    end else begin
      oc_act_nxt = 1'b0;
      if (mode_nxt == mop_pkg::ModeTrip) begin
        if (smoothed <= cfg.high_threshold) begin
          if (!rs_pend_nxt) begin
            rs_pend_nxt = 1'b1;
            rs_nxt      = '0;
          end else if (rs_nxt >= cfg.restart_ticks) begin
            motor_nxt   = 1'b1;
            run_nxt     = '0;
            mode_nxt    = mop_pkg::ModeRunning;
            rs_pend_nxt = 1'b0;
          end
        end else begin
          rs_pend_nxt = 1'b0;
        end
      end else if (motor_nxt) begin
        mode_nxt = (smoothed < cfg.low_threshold) ? mop_pkg::ModeLowCur
                                                  : mop_pkg::ModeRunning;
      end
    end

    res.relay_en = motor_nxt;
    res.mode     = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= mop_pkg::ModeStopped;
      prev_raw_r <= 1'b1;
      stable_r   <= 1'b1;
      motor_r    <= 1'b0;
      oc_act_r   <= 1'b0;
      rs_pend_r  <= 1'b0;
      deb_r      <= '0;
      run_r      <= '0;
      oc_r       <= '0;
      rs_r       <= '0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      prev_raw_r <= prev_raw_nxt;
      stable_r   <= stable_nxt;
      motor_r    <= motor_nxt;
      oc_act_r   <= oc_act_nxt;
      rs_pend_r  <= rs_pend_nxt;
      deb_r      <= deb_nxt;
      run_r      <= run_nxt;
      oc_r       <= oc_nxt;
      rs_r       <= rs_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/motor_overcurrent_protector.sv =====
`default_nettype none
// channel   dir  tdata fields (low bit up)
// in_       in   button_level[0], adc_code[12:1], zeros[15:13]
// out_      out  relay_en[0], mode[3:1], filtered_current[19:4],
//                led_green[20], led_yellow[21], led_blue[22], led_red[23]
// cfg_      in   cfg_addr picks the register, cfg_wdata[15:0] (ema_alpha uses [8:0])
//
// one tick per clock sustained while out_ is not stalled; out_tvalid rises once the in_ transfer
// has passed the input register and then the result register.
// the ema multiply (9 x 17 bits) and the threshold compares after it set the critical path.
// synchronous reset restores the default registers and the stopped state.
// a stalled out_ side holds the result; the input register still takes one more tick.
module motor_overcurrent_protector (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // button_level, adc_code
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // relay_en, mode, filtered_current, leds g/y/b/r
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0] zero_code_r, noise_floor_r, high_thr_r, low_thr_r;
  logic [8:0]  alpha_r;
  mop_pkg::timer_t confirm_r, grace_r, restart_r;

  logic        in_valid_r;
  logic        button_r;
  logic [11:0] adc_r;
  logic        out_valid_r;
  logic [23:0] out_data_r;

  logic        advance;
  logic        step;
  logic [15:0] smoothed_nxt;
  mop_pkg::ctrl_cfg_t ctrl_cfg;
  mop_pkg::ctrl_out_t ctrl_res;
  logic        green;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_code_r   <= 16'd32760;
      noise_floor_r <= 16'd39;
      high_thr_r    <= 16'd655;
      low_thr_r     <= 16'd66;
      alpha_r       <= 9'd51;
      confirm_r     <= mop_pkg::timer_t'(150);
      grace_r       <= mop_pkg::timer_t'(500);
      restart_r     <= mop_pkg::timer_t'(3000);
    end else if (cfg_we) begin
      case (cfg_addr)
        mop_pkg::RegZeroCode:   zero_code_r   <= cfg_wdata;
        mop_pkg::RegNoiseFloor: noise_floor_r <= cfg_wdata;
        mop_pkg::RegHighThr:    high_thr_r    <= cfg_wdata;
        mop_pkg::RegLowThr:     low_thr_r     <= cfg_wdata;
        mop_pkg::RegEmaAlpha:   alpha_r       <= cfg_wdata[8:0];
        mop_pkg::RegConfirm:    confirm_r     <= cfg_wdata;
        mop_pkg::RegGrace:      grace_r       <= cfg_wdata;
        mop_pkg::RegRestart:    restart_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      button_r <= in_tdata[0];
      adc_r    <= in_tdata[12:1];
    end
  end

  assign ctrl_cfg.high_threshold = high_thr_r;
  assign ctrl_cfg.low_threshold  = low_thr_r;
  assign ctrl_cfg.confirm_ticks  = confirm_r;
  assign ctrl_cfg.grace_ticks    = grace_r;
  assign ctrl_cfg.restart_ticks  = restart_r;

  mop_meas u_meas (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .adc_code     (adc_r),
    .zero_code    (zero_code_r),
    .noise_floor  (noise_floor_r),
    .ema_alpha    (alpha_r),
    .smoothed_nxt (smoothed_nxt)
  );

  mop_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .button_level (button_r),
    .smoothed     (smoothed_nxt),
    .cfg          (ctrl_cfg),
    .res          (ctrl_res)
  );

  assign green = (ctrl_res.mode == mop_pkg::ModeRunning) ||
                 (ctrl_res.mode == mop_pkg::ModeLowCur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {ctrl_res.mode == mop_pkg::ModeTrip,
                     ctrl_res.mode == mop_pkg::ModeLowCur,
                     !green,
                     green,
                     smoothed_nxt,
                     ctrl_res.mode,
                     ctrl_res.relay_en};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
